// ===== sv/isq_pkg.sv =====
// Shared widths and the cell data type of the integer ceiling square root core.
package isq_pkg;

  localparam int InputWidth = 31;
  localparam int RootBits   = (InputWidth + 1) / 2;
  localparam int PadWidth   = 2 * RootBits;
  localparam int RemWidth   = RootBits + 3;
  localparam int RootWidth  = 16;
  localparam int CeilWidth  = (RootBits + 1 > RootWidth) ? RootBits + 1 : RootWidth;

  // Partial state of one item on its way down the cell row.
  typedef struct packed {
    logic                valid;
    logic [PadWidth-1:0] bits;
    logic [RemWidth-1:0] rem;
    logic [RootBits-1:0] root;
  } isq_cell_t;

endpackage

// ===== sv/isq_cell.sv =====
// One restoring square root step: brings down two radicand bits, settles one root bit.
module isq_cell
  import isq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  isq_cell_t prev_i,
  output isq_cell_t cell_o
);

  logic [1:0]          pair;
  logic [RemWidth-1:0] rem_sh;
  logic [RemWidth-1:0] trial;
  logic [RemWidth:0]   diff;
  logic                fits;
  isq_cell_t           cell_d;
  isq_cell_t           cell_q;

  always_comb begin
    pair   = prev_i.bits[PadWidth-1 -: 2];
    rem_sh = {prev_i.rem[RemWidth-3:0], pair};
    trial  = RemWidth'({prev_i.root, 2'b01});
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    fits   = ~diff[RemWidth];

    cell_d.valid = prev_i.valid;
    cell_d.bits  = prev_i.bits << 2;
    cell_d.rem   = fits ? diff[RemWidth-1:0] : rem_sh;
    cell_d.root  = RootBits'({prev_i.root, fits});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== sv/isq_out.sv =====
// Ceiling fix and output register at the end of the cell row.
module isq_out
  import isq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  isq_cell_t            last_i,
  input  logic                 out_stall_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  output logic [RootWidth-1:0] root_o
);

  logic [CeilWidth-1:0] ceil_root;
  logic                 out_valid_q;
  logic [RootWidth-1:0] root_q;

  // Round up unless the remainder is zero (perfect square).
  assign ceil_root = CeilWidth'(last_i.root) + CeilWidth'(last_i.rem != '0);
  assign advance_o = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= last_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && last_i.valid) begin
      root_q <= ceil_root[RootWidth-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;

endmodule

// ===== sv/integer_ceil_square_root_core.sv =====
// Top level of the integer ceiling square root core.
//
// Returns ceil(sqrt(value_i)) for an unsigned InputWidth-bit value. The
// radicand runs down a row of RootBits identical cells (16 at the default
// width of 31 bits); each cell brings down two radicand bits and settles one
// root bit by a restoring trial subtract, then registers its remainder and
// partial root for the next cell. A last stage adds one unless the final
// remainder is zero and registers the 16-bit result. Every cell holds its
// own item, so a new transfer can enter each cycle while the output is not
// stalled; the whole row freezes as one while a held result is stalled at
// the output, so in_stall_o follows out_stall_i while out_valid_o is high.
// Zero gives zero, perfect squares give their exact root, and for widths of
// 32 bits and above the result can wrap to its low 16 bits.
module integer_ceil_square_root_core
  import isq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [InputWidth-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RootWidth-1:0]  root_o
);

  isq_cell_t chain [RootBits+1];
  logic      advance;

  // Load the radicand into the head of the row, zero padded to whole bit pairs.
  always_comb begin
    chain[0].valid = in_valid_i;
    chain[0].bits  = PadWidth'(value_i);
    chain[0].rem   = '0;
    chain[0].root  = '0;
  end

  // Hold every cell while the output register is full and stalled.
  assign in_stall_o = ~advance;

  for (genvar g = 0; g < RootBits; g++) begin : g_cell
    isq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .prev_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  isq_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .last_i      (chain[RootBits]),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .root_o      (root_o)
  );

  // The input is only held back by a stalled, occupied output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output");

  // A finished remainder never exceeds twice the floor root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[RootBits].valid |->
      ({1'b0, chain[RootBits].rem} <= {2'b00, chain[RootBits].root, 1'b0}))
    else $error("remainder out of range at end of cell row");

  // A taken result with nothing behind it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !chain[RootBits].valid) |=> !out_valid_o)
    else $error("output valid without a new result");

endmodule
